// File: design/assert_macros.svh
// Assertion macros used by the back part of the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Expression must never be true.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition");

`endif

// File: design/hmtri_pkg.sv
// Shared types and constants of the heightmap triangulation block.
package hmtri_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GRID_ROWS = 3'd0;
  localparam logic [2:0] REG_GRID_COLS = 3'd1;
  localparam logic [2:0] REG_SPACING   = 3'd2;
  localparam logic [2:0] REG_CENTER_X  = 3'd3;
  localparam logic [2:0] REG_CENTER_Y  = 3'd4;

  localparam logic [10:0] GRID_ROWS_RESET = 11'd2;
  localparam logic [10:0] GRID_COLS_RESET = 11'd2;
  localparam logic [31:0] SPACING_RESET   = 32'h0001_0000;

  // Cell queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [10:0] grid_rows;
    logic [10:0] grid_cols;
    logic [31:0] spacing;
    logic [31:0] center_x;
    logic [31:0] center_y;
  } cfg_t;

  // Corner heights of one closed cell
  typedef struct packed {
    logic [31:0] up;
    logic [31:0] ul;
    logic [31:0] left;
    logic [31:0] cur;
    logic        lg;
  } cell_t;

  // Vertex sequencer of the back part
  typedef enum logic [5:0] {
    VTX_0 = 6'b000001,
    VTX_1 = 6'b000010,
    VTX_2 = 6'b000100,
    VTX_3 = 6'b001000,
    VTX_4 = 6'b010000,
    VTX_5 = 6'b100000
  } vtx_t;

endpackage

// File: design/hmtri_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module hmtri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when both ports hit the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/hmtri_front.sv
// Front part: accepts samples, tracks grid position, keeps the line store.
module hmtri_front #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hmtri_pkg::cfg_t                       cfg,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [31:0]                           s_tdata,
  output logic                                  ram_we,
  output logic [$clog2(MAX_COLS)-1:0]           ram_addr,
  output logic [31:0]                           ram_wdata,
  input  logic [31:0]                           ram_rdata,
  input  logic [hmtri_pkg::QCNT_W-1:0]          q_count,
  output logic                                  q_push,
  output logic [$bits(hmtri_pkg::cell_t)+$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] q_data
);
  import hmtri_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RSW = (RW + 1 > 11) ? RW + 1 : 11;
  localparam int CSW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [RW-1:0]  row_count, row_count_next;
  logic [CW-1:0]  col_count, col_count_next;
  logic [31:0]    left_height;
  logic [31:0]    upper_left_height;
  logic [RSW-1:0] rows_eff;
  logic [CSW-1:0] cols_eff;
  logic           end_row, end_grid, accept;

  // Sample held for its registered store read
  logic           v1;
  logic           emit1;
  logic           lg1;
  logic [31:0]    cur1;
  logic [31:0]    left1;
  logic [RW-1:0]  row1;
  logic [CW-1:0]  col1;
  cell_t          closed;

  always_comb begin
    if (cfg.grid_rows == 11'd0) begin
      rows_eff = RSW'(1);
    end else if (RSW'(cfg.grid_rows) > RSW'(MAX_ROWS)) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(cfg.grid_rows);
    end
    if (cfg.grid_cols == 11'd0) begin
      cols_eff = CSW'(1);
    end else if (CSW'(cfg.grid_cols) > CSW'(MAX_COLS)) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(cfg.grid_cols);
    end
  end

  assign end_row  = (CSW'(col_count) + CSW'(1)) >= cols_eff;
  assign end_grid = end_row && ((RSW'(row_count) + RSW'(1)) >= rows_eff);

  // Leave room in the queue for the sample still in flight
  assign s_tready = (q_count + QCNT_W'(v1 && emit1)) < QCNT_W'(QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count;
    if (end_grid) begin
      row_count_next = '0;
      col_count_next = '0;
    end else if (end_row) begin
      row_count_next = row_count + RW'(1);
      col_count_next = '0;
    end else begin
      col_count_next = col_count + CW'(1);
    end
  end

  assign ram_we    = accept;
  assign ram_addr  = col_count;
  assign ram_wdata = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count         <= '0;
      col_count         <= '0;
      left_height       <= '0;
      upper_left_height <= '0;
      v1                <= 1'b0;
    end else begin
      v1 <= accept;
      if (accept) begin
        row_count   <= row_count_next;
        col_count   <= col_count_next;
        left_height <= s_tdata;
      end
      if (v1) begin
        upper_left_height <= ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur1  <= s_tdata;
      left1 <= left_height;
      row1  <= row_count;
      col1  <= col_count;
      emit1 <= (row_count != '0) && (col_count != '0);
      lg1   <= end_grid;
    end
  end

  always_comb begin
    closed.up   = ram_rdata;
    closed.ul   = upper_left_height;
    closed.left = left1;
    closed.cur  = cur1;
    closed.lg   = lg1;
  end

  assign q_push = v1 && emit1;
  assign q_data = {row1, col1, closed};

endmodule

// File: design/hmtri_queue.sv
// Short register queue of closed cells between front and back.
module hmtri_queue #(
  parameter int WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [WIDTH-1:0]              push_data,
  input  logic                          pop,
  output logic [WIDTH-1:0]              head,
  output logic [hmtri_pkg::QCNT_W-1:0]  count
);
  import hmtri_pkg::*;

  logic [WIDTH-1:0]  entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;

  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: design/hmtri_back.sv
// Back part: turns each queued cell into six saturated vertices.
module hmtri_back #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hmtri_pkg::cfg_t                       cfg,
  input  logic                                  head_valid,
  input  logic [$bits(hmtri_pkg::cell_t)+$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] head,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [95:0]                           m_tdata,  // vertex_x, vertex_y, vertex_z
  output logic                                  m_tlast,  // last_of_cell
  output logic                                  m_tuser   // last_of_grid
);
  import hmtri_pkg::*;
  `include "assert_macros.svh"

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int IW = (RW > CW) ? RW : CW;
  localparam int PW = IW + 32;
  localparam int SW = PW + 1;
  localparam int DW = PW + 3;
  localparam logic signed [DW-1:0] SAT_HI = DW'(32'sh7FFF_FFFF);
  localparam logic signed [DW-1:0] SAT_LO = DW'(32'sh8000_0000);

  function automatic logic [31:0] sat_coord(input logic [SW-1:0] p, input logic [31:0] off);
    logic signed [DW-1:0] d;
    d = $signed({2'b00, p}) - DW'($signed(off));
    if (d > SAT_HI) begin
      sat_coord = 32'h7FFF_FFFF;
    end else if (d < SAT_LO) begin
      sat_coord = 32'h8000_0000;
    end else begin
      sat_coord = d[31:0];
    end
  endfunction

  cell_t          head_cell;
  logic [RW-1:0]  head_row;
  logic [CW-1:0]  head_col;
  logic [RW-1:0]  row_m1;
  logic [CW-1:0]  col_m1;

  // Product stage
  logic           pv;
  cell_t          pcell;
  logic [PW-1:0]  px_prod, py_prod;

  // Vertex stage
  logic           cv;
  cell_t          ccell;
  logic [31:0]    xa, xb, ya, yb;
  vtx_t           vtx, vtx_next;

  logic           out_adv, emit_now, c_done, c_take, p_load;
  logic [31:0]    vx, vy, vz;
  logic           vlast;

  assign {head_row, head_col, head_cell} = head;
  assign row_m1 = head_row - RW'(1);
  assign col_m1 = head_col - CW'(1);

  assign out_adv  = !m_tvalid || m_tready;
  assign emit_now = cv && out_adv;
  assign c_done   = emit_now && (vtx == VTX_5);
  assign c_take   = pv && (!cv || c_done);
  assign p_load   = head_valid && (!pv || c_take);
  assign pop      = p_load;

  always_comb begin
    vtx_next = VTX_0;
    vx       = xa;
    vy       = ya;
    vz       = ccell.ul;
    vlast    = 1'b0;
    case (vtx)
      VTX_0: begin
        vtx_next = VTX_1;
      end
      VTX_1: begin
        vtx_next = VTX_2;
        vy       = yb;
        vz       = ccell.up;
      end
      VTX_2: begin
        vtx_next = VTX_3;
        vx       = xb;
        vy       = yb;
        vz       = ccell.cur;
      end
      VTX_3: begin
        vtx_next = VTX_4;
      end
      VTX_4: begin
        vtx_next = VTX_5;
        vx       = xb;
        vy       = yb;
        vz       = ccell.cur;
      end
      VTX_5: begin
        vtx_next = VTX_0;
        vx       = xb;
        vz       = ccell.left;
        vlast    = 1'b1;
      end
      default: begin
        vtx_next = VTX_0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv       <= 1'b0;
      cv       <= 1'b0;
      vtx      <= VTX_0;
      m_tvalid <= 1'b0;
    end else begin
      if (p_load) begin
        pv <= 1'b1;
      end else if (c_take) begin
        pv <= 1'b0;
      end
      if (c_take) begin
        cv  <= 1'b1;
        vtx <= VTX_0;
      end else if (c_done) begin
        cv  <= 1'b0;
        vtx <= VTX_0;
      end else if (emit_now) begin
        vtx <= vtx_next;
      end
      if (emit_now) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      pcell   <= head_cell;
      px_prod <= PW'(row_m1) * PW'(cfg.spacing);
      py_prod <= PW'(col_m1) * PW'(cfg.spacing);
    end
    if (c_take) begin
      ccell <= pcell;
      xa    <= sat_coord({1'b0, px_prod}, cfg.center_x);
      xb    <= sat_coord({1'b0, px_prod} + SW'(cfg.spacing), cfg.center_x);
      ya    <= sat_coord({1'b0, py_prod}, cfg.center_y);
      yb    <= sat_coord({1'b0, py_prod} + SW'(cfg.spacing), cfg.center_y);
    end
    if (emit_now) begin
      m_tdata <= {vz, vy, vx};
      m_tlast <= vlast;
      m_tuser <= vlast && ccell.lg;
    end
  end

  `ASSERT_IMPL(a_grid_end_closes_cell, clk, rst, m_tvalid && m_tuser, m_tlast)
  `ASSERT_NEXT(a_products_move_on, clk, rst, pv && !cv, cv)
  `ASSERT_NEXT(a_sixth_vertex_frees, clk, rst, c_done && !pv, !cv)

endmodule

// File: design/heightmap_grid_to_triangles_unit.sv
// Heightmap grid triangulation: top level with configuration registers.
// A sample that closes a cell gives six vertices, one per cycle while m_tready is high;
// its cell goes through the store read, the cell queue, the product stage and the vertex
// stage. New samples are taken while the cell queue has room, also while earlier vertices
// are still going out. Samples in row 0 or column 0 close no cell; they too are taken while the queue has room.
// Synchronous reset sets registers to their reset values and the position to (0,0);
// the line store is not cleared, so no sweep follows reset.
module heightmap_grid_to_triangles_unit #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // height
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // vertex_x, vertex_y, vertex_z
  output logic        m_tlast,   // last_of_cell
  output logic        m_tuser    // last_of_grid
);
  import hmtri_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int QW = $bits(cell_t) + RW + CW;

  cfg_t              cfg;
  logic [2:0]        reg_idx;
  logic              ram_we;
  logic [CW-1:0]     ram_addr;
  logic [31:0]       ram_wdata, ram_rdata;
  logic [QCNT_W-1:0] q_count;
  logic              q_push, q_pop;
  logic [QW-1:0]     q_data, q_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows <= GRID_ROWS_RESET;
      cfg.grid_cols <= GRID_COLS_RESET;
      cfg.spacing   <= SPACING_RESET;
      cfg.center_x  <= '0;
      cfg.center_y  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_GRID_ROWS: cfg.grid_rows <= pwdata[10:0];
        REG_GRID_COLS: cfg.grid_cols <= pwdata[10:0];
        REG_SPACING:   cfg.spacing   <= pwdata;
        REG_CENTER_X:  cfg.center_x  <= pwdata;
        REG_CENTER_Y:  cfg.center_y  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_ROWS: prdata = 32'(cfg.grid_rows);
      REG_GRID_COLS: prdata = 32'(cfg.grid_cols);
      REG_SPACING:   prdata = cfg.spacing;
      REG_CENTER_X:  prdata = cfg.center_x;
      REG_CENTER_Y:  prdata = cfg.center_y;
      default:       prdata = '0;
    endcase
  end

  hmtri_ram #(
    .WIDTH (32),
    .DEPTH (MAX_COLS)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  hmtri_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  hmtri_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .count     (q_count)
  );

  hmtri_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_count != '0),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

// File: sim/heightmap_grid_to_triangles_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the heightmap grid triangulation unit.
module heightmap_grid_to_triangles_unit_tb;
  import hmtri_pkg::*;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_COLS     = 1024;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 310;
  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        cell_end;
    logic        grid_end;
  } vertex_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // height
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;   // vertex_x, vertex_y, vertex_z
  logic        m_tlast;   // last_of_cell
  logic        m_tuser;   // last_of_grid

  // Shadow registers and grid state of the predictor
  logic [10:0] rows_reg, cols_reg;
  logic [31:0] spacing_reg, center_x_reg, center_y_reg;
  logic [31:0] line_store [0:MAX_COLS-1];
  logic [31:0] left_h, upper_left_h;
  int unsigned row_pos, col_pos;

  vertex_t     expected_vertices[$];
  logic [31:0] pending_heights[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          sent_count = 0;
  int          taken_count = 0;
  bit          no_gaps = 1'b0;
  int          src_gap = 0;
  int          sink_stall = 0;

  always #2 clk = ~clk;

  heightmap_grid_to_triangles_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  function automatic int unsigned clamp_size(logic [10:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // Exact index*spacing - offset, saturated to signed 32 bits
  function automatic logic [31:0] grid_coord(int unsigned idx, logic [31:0] off);
    logic [63:0]        prod;
    logic signed [63:0] pos;
    prod = 64'(idx) * {32'd0, spacing_reg};
    pos = $signed(prod) - $signed({{32{off[31]}}, off});
    if (pos > SAT_HI) return 32'h7FFF_FFFF;
    if (pos < SAT_LO) return 32'h8000_0000;
    return pos[31:0];
  endfunction

  function automatic vertex_t make_vertex(int unsigned i, int unsigned j, logic [31:0] z,
                                          logic cell_end, logic grid_end);
    vertex_t v;
    v.x = grid_coord(i, center_x_reg);
    v.y = grid_coord(j, center_y_reg);
    v.z = z;
    v.cell_end = cell_end;
    v.grid_end = grid_end;
    return v;
  endfunction

  task automatic expect_vertex(vertex_t v);
    expected_vertices = {expected_vertices, v};
  endtask

  task automatic add_height(logic [31:0] h);
    pending_heights = {pending_heights, h};
  endtask

  task automatic triangulate_sample(logic [31:0] h);
    int unsigned rows, cols, r, c, idx;
    logic [31:0] up;
    bit end_row, end_grid;
    rows = clamp_size(rows_reg, MAX_ROWS);
    cols = clamp_size(cols_reg, MAX_COLS);
    r = row_pos;
    c = col_pos;
    idx = (c < MAX_COLS) ? c : 0;
    up = line_store[idx];
    end_row = (c + 1 >= cols);
    end_grid = end_row && (r + 1 >= rows);
    if (r >= 1 && c >= 1) begin
      expect_vertex(make_vertex(r - 1, c - 1, upper_left_h, 1'b0, 1'b0));
      expect_vertex(make_vertex(r - 1, c, up, 1'b0, 1'b0));
      expect_vertex(make_vertex(r, c, h, 1'b0, 1'b0));
      expect_vertex(make_vertex(r - 1, c - 1, upper_left_h, 1'b0, 1'b0));
      expect_vertex(make_vertex(r, c, h, 1'b0, 1'b0));
      expect_vertex(make_vertex(r, c - 1, left_h, 1'b1, end_grid));
    end
    upper_left_h = up;
    left_h = h;
    line_store[idx] = h;
    if (end_grid) begin
      row_pos = 0;
      col_pos = 0;
    end else if (end_row) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_height();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 32'h7FFF_FFFF;
    if (roll < 16) return 32'h8000_0000;
    if (roll < 20) return 32'h0000_0000;
    if (roll < 24) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(9);
    case (roll)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h0001_0000;
      5, 6: return $urandom_range(32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // Source side: hold the item until its transfer, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || taken_count == sent_count) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_heights.size() != 0) begin
        s_tdata <= pending_heights.pop_front();
        s_tvalid <= 1'b1;
        sent_count++;
        src_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      sink_stall = ($urandom_range(3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        triangulate_sample(s_tdata);
        taken_count++;
      end
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[31:0];
        got.y = m_tdata[63:32];
        got.z = m_tdata[95:64];
        got.cell_end = m_tlast;
        got.grid_end = m_tuser;
        if (expected_vertices.size() == 0) begin
          error_count++;
          $display("%0t: vertex with none expected: x=%h y=%h z=%h last=%b grid=%b",
                   $time, got.x, got.y, got.z, got.cell_end, got.grid_end);
        end else begin
          want = expected_vertices.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: vertex mismatch: expected x=%h y=%h z=%h last=%b grid=%b",
                     $time, want.x, want.y, want.z, want.cell_end, want.grid_end);
            $display("%0t:                  actual   x=%h y=%h z=%h last=%b grid=%b",
                     $time, got.x, got.y, got.z, got.cell_end, got.grid_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_GRID_ROWS: rows_reg = value[10:0];
      REG_GRID_COLS: cols_reg = value[10:0];
      REG_SPACING:   spacing_reg = value;
      REG_CENTER_X:  center_x_reg = value;
      REG_CENTER_Y:  center_y_reg = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic queue_heights(int n);
    repeat (n) add_height(pick_height());
  endtask

  // Wait for all transfers and vertices, then let a sample with no cell settle
  task automatic wait_idle();
    while (pending_heights.size() != 0 || s_tvalid || expected_vertices.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Never grow the column count mid-grid: the next row would read unwritten entries
  task automatic randomize_config();
    bit          fresh;
    int          roll;
    logic [10:0] size;
    fresh = (row_pos == 0 && col_pos == 0);
    roll = $urandom_range(99);
    if (roll < 70) begin
      size = (roll < 4) ? 11'd0 : (roll < 7) ? 11'd2047 : 11'($urandom_range(6, 1));
      write_reg(REG_GRID_ROWS, {21'd0, size});
    end
    roll = $urandom_range(99);
    if (roll < 70) begin
      size = (roll < 4) ? 11'd0 : (roll < 7 && fresh) ? 11'd1100 : 11'($urandom_range(8, 1));
      if (!fresh && clamp_size(size, MAX_COLS) > clamp_size(cols_reg, MAX_COLS))
        size = cols_reg;
      write_reg(REG_GRID_COLS, {21'd0, size});
    end
    if ($urandom_range(1)) write_reg(REG_SPACING, pick_word());
    if ($urandom_range(1)) write_reg(REG_CENTER_X, pick_word());
    if ($urandom_range(1)) write_reg(REG_CENTER_Y, pick_word());
  endtask

  initial begin
    int random_count;
    int n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rows_reg = GRID_ROWS_RESET;
    cols_reg = GRID_COLS_RESET;
    spacing_reg = SPACING_RESET;
    center_x_reg = '0;
    center_y_reg = '0;
    foreach (line_store[k]) line_store[k] = '0;
    left_h = '0;
    upper_left_h = '0;
    row_pos = 0;
    col_pos = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset geometry: one cell with extreme heights
    add_height(32'h7FFF_FFFF);
    add_height(32'h8000_0000);
    add_height(32'h0000_0000);
    add_height(32'hFFFF_FFFF);
    wait_idle();

    // Coordinates saturate at the top of the signed range on both axes
    write_reg(REG_GRID_ROWS, 32'd3);
    write_reg(REG_GRID_COLS, 32'd3);
    write_reg(REG_SPACING, 32'hFFFF_FFFF);
    write_reg(REG_CENTER_X, 32'h8000_0000);
    write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
    queue_heights(9);
    wait_idle();

    // Zero sizes act as one: every sample is a whole grid, nothing comes out
    write_reg(REG_GRID_ROWS, 32'd0);
    write_reg(REG_GRID_COLS, 32'd0);
    write_reg(REG_SPACING, 32'd0);
    write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(REG_CENTER_Y, 32'h8000_0000);
    queue_heights(2);
    wait_idle();

    // Single row, then single column
    write_reg(REG_GRID_ROWS, 32'd1);
    write_reg(REG_GRID_COLS, 32'd3);
    queue_heights(3);
    wait_idle();
    write_reg(REG_GRID_ROWS, 32'd2);
    write_reg(REG_GRID_COLS, 32'd1);
    queue_heights(2);
    wait_idle();

    // Shrink columns mid-grid: position past the new width wraps at the next sample
    write_reg(REG_GRID_ROWS, 32'd3);
    write_reg(REG_GRID_COLS, 32'd4);
    write_reg(REG_SPACING, 32'h0001_8000);
    write_reg(REG_CENTER_X, 32'h0001_0000);
    write_reg(REG_CENTER_Y, 32'hFFFF_0000);
    queue_heights(6);
    wait_idle();
    write_reg(REG_GRID_COLS, 32'd2);
    queue_heights(3);
    wait_idle();

    // Oversized grid acts as the maximum width; close the row early by shrinking
    no_gaps = 1'b1;
    write_reg(REG_GRID_ROWS, 32'd2047);
    write_reg(REG_GRID_COLS, 32'd2047);
    queue_heights(12);
    wait_idle();
    write_reg(REG_GRID_COLS, 32'd5);
    write_reg(REG_GRID_ROWS, 32'd2);
    queue_heights(1);
    wait_idle();

    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(4) == 0);
      randomize_config();
      n = $urandom_range(40, 5);
      queue_heights(n);
      random_count += n;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
